// ----- rtl/rn2i_pkg.sv -----
package rn2i_pkg;

	localparam int unsigned MAX_LETTERS_DEF = 20;

	localparam int unsigned VALUE_W  = 14;
	localparam int unsigned STATUS_W = 4;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned RUN_W    = 3;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned LVAL_W   = 10;

	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	// Letter codes, ordered by value; zero means no letter.
	localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
	localparam logic [CODE_W-1:0] CODE_I    = 3'd1;
	localparam logic [CODE_W-1:0] CODE_V    = 3'd2;
	localparam logic [CODE_W-1:0] CODE_X    = 3'd3;
	localparam logic [CODE_W-1:0] CODE_L    = 3'd4;
	localparam logic [CODE_W-1:0] CODE_C    = 3'd5;
	localparam logic [CODE_W-1:0] CODE_D    = 3'd6;
	localparam logic [CODE_W-1:0] CODE_M    = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_LETTER  = 4'd1;
	localparam logic [STATUS_W-1:0] ST_REPEATS     = 4'd2;
	localparam logic [STATUS_W-1:0] ST_VLD_MISUSE  = 4'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_SUB     = 4'd4;
	localparam logic [STATUS_W-1:0] ST_SUB_THEN_ADD = 4'd5;
	localparam logic [STATUS_W-1:0] ST_RUN_BEFORE  = 4'd6;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 4'd7;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 4'd8;

	localparam logic [RUN_W-1:0] RUN_LIMIT   = 3'd3;
	localparam logic [RUN_W-1:0] RUN_LIMIT_M = 3'd5;

	typedef struct packed {
		logic [VALUE_W-1:0]  total;
		logic [CODE_W-1:0]   pending;
		logic [CODE_W-1:0]   prev;
		logic [CODE_W-1:0]   prev2;
		logic [RUN_W-1:0]    run;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] err;
	} rn2i_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value;
	} rn2i_result_t;

	function automatic logic [CODE_W-1:0] decode_letter(input logic [7:0] ch);
		logic [CODE_W-1:0] code;
		unique case (ch) inside
			"I", "i": code = CODE_I;
			"V", "v": code = CODE_V;
			"X", "x": code = CODE_X;
			"L", "l": code = CODE_L;
			"C", "c": code = CODE_C;
			"D", "d": code = CODE_D;
			"M", "m": code = CODE_M;
			default:  code = CODE_NONE;
		endcase
		return code;
	endfunction

	function automatic logic [LVAL_W-1:0] letter_value(input logic [CODE_W-1:0] code);
		logic [LVAL_W-1:0] v;
		unique case (code)
			CODE_I:  v = 10'd1;
			CODE_V:  v = 10'd5;
			CODE_X:  v = 10'd10;
			CODE_L:  v = 10'd50;
			CODE_C:  v = 10'd100;
			CODE_D:  v = 10'd500;
			CODE_M:  v = 10'd1000;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

	function automatic logic [VALUE_W-1:0] add_sat(input logic [VALUE_W-1:0] a,
			input logic [LVAL_W-1:0] b);
		logic [VALUE_W:0] s;
		s = {1'b0, a} + {{(VALUE_W + 1 - LVAL_W){1'b0}}, b};
		return s[VALUE_W] ? VALUE_MAX : s[VALUE_W-1:0];
	endfunction

endpackage

// ----- rtl/roman_numeral_to_integer_core.sv -----
// Roman numeral to integer converter.
// The input stream carries one ASCII character per item in s_tdata, upper or
// lower case, with s_tlast on the final character of a numeral. After that
// final item one result item appears on the output stream: the value and a
// status code, where status zero means a well-formed numeral and any other
// status forces the value to zero. Items without s_tlast produce no output.
// A NUL character with s_tlast ends the numeral without adding a letter.
// The final character is registered in the input stage, and its result in
// the output register that drives m_tvalid. One item is accepted every
// cycle unless the output stalls: the input register feeds a single stage
// of letter checks and saturating adds, whose result lands in the output
// register. When the receiver holds m_tready low with a result waiting, the
// whole pipeline freezes and s_tready falls until the result is taken.
// Reset clears the running state, the input valid and the output valid, so
// the first item after reset begins a new numeral. The state also returns
// to empty after every result item.
module roman_numeral_to_integer_core #(
	parameter int unsigned MAX_LETTERS = rn2i_pkg::MAX_LETTERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] letter
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [13:0] value, [17:14] status, rest zero
);

	logic                   advance;
	logic                   in_valid_s1;
	logic [7:0]             letter_s1;
	logic                   last_s1;
	rn2i_pkg::rn2i_state_t  state_q;
	rn2i_pkg::rn2i_state_t  state_d;
	rn2i_pkg::rn2i_result_t result;
	rn2i_pkg::rn2i_result_t result_q;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			state_q     <= '0;
		end else if (advance) begin
			in_valid_s1 <= s_tvalid;
			if (in_valid_s1) begin
				state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			letter_s1 <= s_tdata;
			last_s1   <= s_tlast;
		end
	end

	rn2i_step #(
		.MAX_LETTERS(MAX_LETTERS)
	) u_step (
		.state_q    (state_q),
		.letter     (letter_s1),
		.last_letter(last_s1),
		.state_d    (state_d),
		.result     (result)
	);

	rn2i_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.load    (in_valid_s1 && last_s1),
		.result  (result),
		.valid   (m_tvalid),
		.result_q(result_q)
	);

	assign m_tdata = {6'd0, result_q.status, result_q.value};

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_valid_s1 && last_s1))
		else $error("result item without a final character");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_valid_s1 && last_s1) |=> (state_q == '0))
		else $error("state not cleared after a result");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_q.status != rn2i_pkg::ST_OK) |-> (result_q.value == '0))
		else $error("nonzero value with an error status");

	a_ok_value_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_q.status == rn2i_pkg::ST_OK) |-> (result_q.value != '0))
		else $error("zero value with ok status");

endmodule

// ----- rtl/rn2i_step.sv -----
module rn2i_step #(
	parameter int unsigned MAX_LETTERS = rn2i_pkg::MAX_LETTERS_DEF
) (
	input  rn2i_pkg::rn2i_state_t  state_q,
	input  logic [7:0]             letter,
	input  logic                   last_letter,
	output rn2i_pkg::rn2i_state_t  state_d,
	output rn2i_pkg::rn2i_result_t result
);

	logic [rn2i_pkg::CODE_W-1:0]   c;
	logic [rn2i_pkg::CODE_W-1:0]   p;
	logic [rn2i_pkg::CODE_W-1:0]   b;
	logic [rn2i_pkg::RUN_W:0]      run_inc;
	logic [rn2i_pkg::RUN_W-1:0]    run;
	logic [rn2i_pkg::RUN_W-1:0]    run_limit;
	logic [rn2i_pkg::STATUS_W-1:0] e;
	logic                          sub_ok;
	rn2i_pkg::rn2i_state_t         mid;
	logic [rn2i_pkg::STATUS_W-1:0] err_f;
	logic [rn2i_pkg::VALUE_W-1:0]  total_f;

	always_comb begin
		c         = rn2i_pkg::decode_letter(letter);
		p         = state_q.prev;
		b         = state_q.prev2;
		run_inc   = {1'b0, state_q.run} + 4'd1;
		run_limit = (c == rn2i_pkg::CODE_M) ? rn2i_pkg::RUN_LIMIT_M : rn2i_pkg::RUN_LIMIT;
		sub_ok    = (p == rn2i_pkg::CODE_I || p == rn2i_pkg::CODE_X || p == rn2i_pkg::CODE_C)
			&& ({1'b0, c} <= {1'b0, p} + 4'd2);
		run       = '0;
		e         = rn2i_pkg::ST_OK;

		if (c == rn2i_pkg::CODE_NONE) begin
			e = rn2i_pkg::ST_BAD_LETTER;
		end else begin
			if (c == p) begin
				run = run_inc[rn2i_pkg::RUN_W] ? '1 : run_inc[rn2i_pkg::RUN_W-1:0];
			end else begin
				run = 3'd1;
			end
			if (run > run_limit) begin
				e = rn2i_pkg::ST_REPEATS;
			end else if ((p == rn2i_pkg::CODE_V || p == rn2i_pkg::CODE_L ||
					p == rn2i_pkg::CODE_D) && c >= p) begin
				e = rn2i_pkg::ST_VLD_MISUSE;
			end else if (p != rn2i_pkg::CODE_NONE && c > p && !sub_ok) begin
				e = rn2i_pkg::ST_BAD_SUB;
			end else if (b != rn2i_pkg::CODE_NONE && b < p && c == b) begin
				e = rn2i_pkg::ST_SUB_THEN_ADD;
			end else if (p != rn2i_pkg::CODE_NONE && c > p && state_q.run >= 3'd2) begin
				e = rn2i_pkg::ST_RUN_BEFORE;
			end
		end
		if (e == rn2i_pkg::ST_OK && state_q.count >= rn2i_pkg::COUNT_W'(MAX_LETTERS)) begin
			e = rn2i_pkg::ST_TOO_LONG;
		end

		mid = state_q;
		if (state_q.err == rn2i_pkg::ST_OK) begin
			mid.err = e;
		end
		if (state_q.count != '1) begin
			mid.count = state_q.count + 5'd1;
		end
		if (c == rn2i_pkg::CODE_NONE) begin
			mid.pending = rn2i_pkg::CODE_NONE;
		end else if (state_q.pending == rn2i_pkg::CODE_NONE) begin
			mid.pending = c;
		end else if (state_q.pending < c) begin
			mid.total = rn2i_pkg::add_sat(state_q.total,
				rn2i_pkg::letter_value(c) - rn2i_pkg::letter_value(state_q.pending));
			mid.pending = rn2i_pkg::CODE_NONE;
		end else begin
			mid.total = rn2i_pkg::add_sat(state_q.total,
				rn2i_pkg::letter_value(state_q.pending));
			mid.pending = c;
		end
		mid.prev2 = p;
		mid.prev  = c;
		mid.run   = run;

		// A NUL character adds no letter.
		if (letter == 8'd0) begin
			mid = state_q;
		end

		err_f = mid.err;
		if (mid.err == rn2i_pkg::ST_OK && mid.count == '0) begin
			err_f = rn2i_pkg::ST_EMPTY;
		end
		total_f = rn2i_pkg::add_sat(mid.total, rn2i_pkg::letter_value(mid.pending));

		result.status = err_f;
		result.value  = (err_f != rn2i_pkg::ST_OK) ? '0 : total_f;

		state_d = last_letter ? '0 : mid;
	end

endmodule

// ----- rtl/rn2i_out_stage.sv -----
module rn2i_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   load,
	input  rn2i_pkg::rn2i_result_t result,
	output logic                   valid,
	output rn2i_pkg::rn2i_result_t result_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (advance) begin
			valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			result_q <= result;
		end
	end

endmodule
